>>> hw/rtl/spq_pkg.sv
// shared types and constants for the sorted priority queue
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CAPACITY  = 16;
	localparam int RANK_BITS = 8;

	localparam int VALUE_W = 32;
	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [VALUE_W-1:0]   value;
		logic [RANK_BITS-1:0] rank;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic             load;
		logic [1:0]       status;
		logic             empty;
		logic [CNT_W-1:0] occ;
		entry_t           head;
		entry_t           tail;
	} result_t;

endpackage

>>> hw/rtl/spq_slot_ram.sv
// slot storage: one write port, one read port with registered read data
// depends on spq_pkg
`timescale 1ns / 1ps

module spq_slot_ram (
	input  logic              clk,
	input  spq_pkg::ram_req_t req,
	output spq_pkg::entry_t   rd_data
);

	spq_pkg::entry_t mem [spq_pkg::CAPACITY];
	spq_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= mem[req.raddr];
		end
	end

	assign rd_data = rd_q;

endmodule

>>> hw/rtl/spq_ctrl.sv
// sequencer for insert and remove: walks the slots one at a time with one
// slot ram access per state and one rank comparator; depends on spq_pkg
`timescale 1ns / 1ps

module spq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         operation,
	input  logic [spq_pkg::VALUE_W-1:0]  item_value,
	input  logic [7:0]                   item_rank,
	input  logic                         out_free,
	output spq_pkg::result_t             rsp_load,
	output spq_pkg::ram_req_t            ram_req,
	input  spq_pkg::entry_t              rd_data
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_INS_RD  = 8'b0000_0010,
		S_INS_CMP = 8'b0000_0100,
		S_REM_RD  = 8'b0000_1000,
		S_REM_WR  = 8'b0001_0000,
		S_FIN     = 8'b0010_0000,
		S_HEAD    = 8'b0100_0000,
		S_TAIL    = 8'b1000_0000
	} state_t;

	state_t                        state_q, state_d;
	logic [spq_pkg::CNT_W-1:0]     count_q, count_d;
	logic [spq_pkg::CNT_W-1:0]     idx_q, idx_d;
	logic [spq_pkg::IDX_W-1:0]     hole_q, hole_d;
	logic [1:0]                    status_q, status_d;
	spq_pkg::entry_t               new_q, new_d;
	spq_pkg::entry_t               head_q, head_d;
	logic [spq_pkg::CNT_W-1:0]     idx_m1;
	logic [spq_pkg::CNT_W-1:0]     cnt_m1;
	logic [spq_pkg::IDX_W-1:0]     hole_m1;
	logic                          rank_gt;

	assign idx_m1  = idx_q - spq_pkg::CNT_W'(1);
	assign cnt_m1  = count_q - spq_pkg::CNT_W'(1);
	assign hole_m1 = hole_q - spq_pkg::IDX_W'(1);
	// shared comparator: stored entry moves back only if strictly larger
	assign rank_gt = rd_data.rank > new_q.rank;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		hole_d   = hole_q;
		status_d = status_q;
		new_d    = new_q;
		head_d   = head_q;
		ram_req  = '0;
		rsp_load = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					new_d.value = item_value;
					new_d.rank  = item_rank[spq_pkg::RANK_BITS-1:0];
					status_d    = spq_pkg::STATUS_DONE;
					if (operation == spq_pkg::OP_INSERT) begin
						if (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY)) begin
							status_d = spq_pkg::STATUS_FULL;
							state_d  = S_FIN;
						end else begin
							hole_d  = count_q[spq_pkg::IDX_W-1:0];
							state_d = S_INS_RD;
						end
					end else begin
						if (count_q == '0) begin
							status_d = spq_pkg::STATUS_EMPTY;
							state_d  = S_FIN;
						end else begin
							idx_d   = spq_pkg::CNT_W'(1);
							state_d = S_REM_RD;
						end
					end
				end
			end
			S_INS_RD: begin
				if (hole_q == '0) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = '0;
					ram_req.wdata = new_q;
					count_d       = count_q + spq_pkg::CNT_W'(1);
					state_d       = S_FIN;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = hole_m1;
					state_d       = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = hole_q;
				if (rank_gt) begin
					ram_req.wdata = rd_data;
					hole_d        = hole_m1;
					state_d       = S_INS_RD;
				end else begin
					ram_req.wdata = new_q;
					count_d       = count_q + spq_pkg::CNT_W'(1);
					state_d       = S_FIN;
				end
			end
			S_REM_RD: begin
				if (idx_q == count_q) begin
					count_d = cnt_m1;
					state_d = S_FIN;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = idx_q[spq_pkg::IDX_W-1:0];
					state_d       = S_REM_WR;
				end
			end
			S_REM_WR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = idx_m1[spq_pkg::IDX_W-1:0];
				ram_req.wdata = rd_data;
				idx_d         = idx_q + spq_pkg::CNT_W'(1);
				state_d       = S_REM_RD;
			end
			S_FIN: begin
				if (count_q == '0) begin
					// empty queue reports zero head and tail
					if (out_free) begin
						rsp_load.load   = 1'b1;
						rsp_load.status = status_q;
						rsp_load.empty  = 1'b1;
						rsp_load.occ    = '0;
						state_d         = S_IDLE;
					end
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = '0;
					state_d       = S_HEAD;
				end
			end
			S_HEAD: begin
				head_d        = rd_data;
				ram_req.re    = 1'b1;
				ram_req.raddr = cnt_m1[spq_pkg::IDX_W-1:0];
				state_d       = S_TAIL;
			end
			S_TAIL: begin
				if (out_free) begin
					rsp_load.load   = 1'b1;
					rsp_load.status = status_q;
					rsp_load.empty  = 1'b0;
					rsp_load.occ    = count_q;
					rsp_load.head   = head_q;
					rsp_load.tail   = rd_data;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		hole_q   <= hole_d;
		status_q <= status_d;
		new_q    <= new_d;
		head_q   <= head_d;
	end

endmodule

>>> hw/rtl/sorted_priority_queue_core.sv
// top level of the sorted priority queue: sequencer, slot ram, result register
// depends on spq_pkg, spq_slot_ram, spq_ctrl
//
//  channel | handshake            | payload
//  req     | req_valid, req_ready | operation, item_value, item_rank
//  rsp     | rsp_valid, rsp_ready | status, is_empty, occupancy, head/tail value and rank
//
// one ram access per state sets the pace: an insert reads and moves back each entry
// of larger rank, a remove reads and moves forward each entry behind the head; then
// head and tail are read, unless the queue is empty, and the result waits to load
// while the output register is busy. full or empty rejections skip the slot walk.
// reset clears the sequencer and the entry count; slots are never read unwritten.
// a result waiting in the output register does not block the next request
// until that request is ready to report.
`timescale 1ns / 1ps

module sorted_priority_queue_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                operation,
	input  logic signed [31:0]  item_value,
	input  logic        [7:0]   item_rank,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic        [1:0]   status,
	output logic                is_empty,
	output logic        [4:0]   occupancy,
	output logic signed [31:0]  head_value,
	output logic        [7:0]   head_rank,
	output logic signed [31:0]  tail_value,
	output logic        [7:0]   tail_rank
);

	spq_pkg::ram_req_t ram_req;
	spq_pkg::entry_t   rd_data;
	spq_pkg::result_t  rsp_load;
	spq_pkg::result_t  rsp_q;
	logic              rsp_valid_q;
	logic              out_free;

	assign out_free = !rsp_valid_q || rsp_ready;

	spq_slot_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	spq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.operation  (operation),
		.item_value (item_value),
		.item_rank  (item_rank),
		.out_free   (out_free),
		.rsp_load   (rsp_load),
		.ram_req    (ram_req),
		.rd_data    (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load.load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load.load) begin
			rsp_q <= rsp_load;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = rsp_q.status;
	assign is_empty   = rsp_q.empty;
	assign occupancy  = 5'(rsp_q.occ);
	assign head_value = rsp_q.head.value;
	assign head_rank  = 8'(rsp_q.head.rank);
	assign tail_value = rsp_q.tail.value;
	assign tail_rank  = 8'(rsp_q.tail.rank);

endmodule

>>> test/tb_sorted_priority_queue_core.sv
// testbench for sorted_priority_queue_core: directed and random insert/remove traffic
// checked against a stable sorted-queue predictor; depends on spq_pkg and the core rtl
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASE_ITEMS   = 333;

	typedef struct packed {
		logic [1:0]      status;
		logic            empty;
		logic [4:0]      occ;
		spq_pkg::entry_t head;
		spq_pkg::entry_t tail;
	} report_t;

	class queue_scoreboard;
		spq_pkg::entry_t held[$];
		report_t         awaited[$];
		int              errors;

		function void note_error(string what, logic [31:0] want, logic [31:0] got);
			errors++;
			if (errors <= 10)
				$display("mismatch %s: expected %h actual %h", what, want, got);
		endfunction

		// advance the predicted queue by one accepted request transaction
		function void note_request(logic op, logic [31:0] value, logic [7:0] rank);
			report_t         r;
			spq_pkg::entry_t e;
			int              pos;
			r = '0;
			r.status = spq_pkg::STATUS_DONE;
			if (op == spq_pkg::OP_INSERT) begin
				if (held.size() >= spq_pkg::CAPACITY) begin
					r.status = spq_pkg::STATUS_FULL;
				end else begin
					e.value = value;
					e.rank  = rank[spq_pkg::RANK_BITS-1:0];
					pos = 0;
					// equal ranks go behind existing ones
					while (pos < held.size() && held[pos].rank <= e.rank)
						pos++;
					held.insert(pos, e);
				end
			end else if (held.size() == 0) begin
				r.status = spq_pkg::STATUS_EMPTY;
			end else begin
				void'(held.pop_front());
			end
			r.empty = (held.size() == 0);
			r.occ   = 5'(held.size());
			if (held.size() != 0) begin
				r.head = held[0];
				r.tail = held[held.size()-1];
			end
			awaited.push_back(r);
		endfunction

		function void check_response(report_t got);
			report_t want;
			if (awaited.size() == 0) begin
				note_error("unexpected response", '0, 32'(got.occ));
				return;
			end
			want = awaited.pop_front();
			if (want.status !== got.status)
				note_error("status", 32'(want.status), 32'(got.status));
			if (want.empty !== got.empty)
				note_error("is_empty", 32'(want.empty), 32'(got.empty));
			if (want.occ !== got.occ)
				note_error("occupancy", 32'(want.occ), 32'(got.occ));
			if (want.head.value !== got.head.value)
				note_error("head_value", want.head.value, got.head.value);
			if (want.head.rank !== got.head.rank)
				note_error("head_rank", 32'(want.head.rank), 32'(got.head.rank));
			if (want.tail.value !== got.tail.value)
				note_error("tail_value", want.tail.value, got.tail.value);
			if (want.tail.rank !== got.tail.rank)
				note_error("tail_rank", 32'(want.tail.rank), 32'(got.tail.rank));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_ready;
	logic               operation;
	logic signed [31:0] item_value;
	logic        [7:0]  item_rank;
	logic               rsp_valid;
	logic               rsp_ready;
	logic        [1:0]  status;
	logic               is_empty;
	logic        [4:0]  occupancy;
	logic signed [31:0] head_value;
	logic        [7:0]  head_rank;
	logic signed [31:0] tail_value;
	logic        [7:0]  tail_rank;

	queue_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int cycle_count = 0;

	logic [7:0] fill_ranks [16] = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd0, 8'd255, 8'd7, 8'd128,
		8'd1, 8'd254, 8'd0, 8'd64, 8'd128, 8'd3, 8'd255, 8'd100};

	sorted_priority_queue_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.operation  (operation),
		.item_value (item_value),
		.item_rank  (item_rank),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.is_empty   (is_empty),
		.occupancy  (occupancy),
		.head_value (head_value),
		.head_rank  (head_rank),
		.tail_value (tail_value),
		.tail_rank  (tail_rank)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// response side: random back-pressure and checking
	always @(posedge clk) begin
		report_t got;
		if (arst_n && rsp_valid && rsp_ready) begin
			got.status     = status;
			got.empty      = is_empty;
			got.occ        = occupancy;
			got.head.value = head_value;
			got.head.rank  = head_rank;
			got.tail.value = tail_value;
			got.tail.rank  = tail_rank;
			sb.check_response(got);
		end
		rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic drive_request(input logic op, input logic [31:0] value, input logic [7:0] rank);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		operation  <= op;
		item_value <= value;
		item_rank  <= rank;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(op, value, rank);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.awaited.size() != 0);
	endtask

	// mostly bursts biased toward filling or draining, so full and empty both come up
	task automatic random_traffic(input int count);
		int          insert_pct;
		logic        op;
		logic [31:0] value;
		logic [7:0]  rank;
		insert_pct = 50;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(2))
					0: insert_pct = 20;
					1: insert_pct = 50;
					default: insert_pct = 85;
				endcase
			end
			op = ($urandom_range(99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
			case ($urandom_range(3))
				0: rank = 8'($urandom_range(3));
				1: rank = $urandom_range(1) ? 8'hFF : 8'h00;
				default: rank = 8'($urandom_range(255));
			endcase
			case ($urandom_range(15))
				0: value = 32'h7FFF_FFFF;
				1: value = 32'h8000_0000;
				default: value = $urandom;
			endcase
			drive_request(op, value, rank);
		end
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n     <= 1'b0;
		req_valid  <= 1'b0;
		operation  <= spq_pkg::OP_INSERT;
		item_value <= '0;
		item_rank  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 8;
		recv_idle_pct = 49;

		// remove on empty, with all payload bits set to show they are ignored
		drive_request(spq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 8'hFF);
		for (int i = 0; i < spq_pkg::CAPACITY; i++) begin
			drive_request(spq_pkg::OP_INSERT,
				(i == 0) ? 32'h7FFF_FFFF :
				(i == 1) ? 32'h8000_0000 :
				(i == 2) ? 32'h0000_0000 :
				(i == 3) ? 32'hFFFF_FFFF : {8'(i), 24'hA5C3_96},
				fill_ranks[i]);
		end
		// insert into a full queue
		drive_request(spq_pkg::OP_INSERT, 32'h1234_5678, 8'h00);
		repeat (3) drive_request(spq_pkg::OP_REMOVE, $urandom, 8'($urandom_range(255)));
		wait_drained();

		random_traffic(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 49;
		recv_idle_pct = 8;
		random_traffic(PHASE_ITEMS);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_traffic(PHASE_ITEMS);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sorted_priority_queue_core.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_slot_ram.sv
hw/rtl/spq_ctrl.sv
hw/rtl/sorted_priority_queue_core.sv
test/tb_sorted_priority_queue_core.sv
